FILE: rtl/lpu_pkg.sv
// Shared types, constants and fixed-point helpers for the lens point undistortion block.
// No dependencies; used by lpu_div, lpu_iter and lens_point_undistort_top.
`timescale 1ns / 1ps

package lpu_pkg;

  // Refinement passes over each point
  localparam int ITERATIONS = 6;

  // Divider: one quotient bit per stage, plus an input and an output register
  localparam int DIV_QBITS = 32;
  localparam int DIV_LAT   = DIV_QBITS + 2;

  // Stage numbers inside one refinement pass
  localparam int ST_A = 0;   // raw squares and cross product
  localparam int ST_B = 1;   // round and clip xx, yy, xy
  localparam int ST_C = 2;   // r2
  localparam int ST_D = 3;   // r2 + 2xx, r2 + 2yy, first coefficient products
  localparam int ST_E = 4;   // Horner step on k2, tangential products
  localparam int ST_F = 5;   // Horner product, tangential offsets
  localparam int ST_G = 6;   // Horner step on k1, remove tangential offset
  localparam int ST_H = 7;   // last Horner product
  localparam int ST_I = 8;   // polynomial
  localparam int ST_J = 9;   // divider operands
  localparam int ST_K = ST_J + DIV_LAT + 1;  // scale products
  localparam int ST_L = ST_K + 1;            // rounded result
  localparam int ITER_LAT = ST_L + 1;

  localparam logic signed [31:0] Q30_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q30_MIN = 32'sh8000_0000;
  localparam logic signed [19:0] OUT_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] OUT_MIN = 20'sh80000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_RADIAL_K3  = 3'd6,
    REG_TANGENTIAL = 3'd7
  } lpu_reg_t;

  // Context that travels between passes
  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
  } lpu_ctx_t;

  // Context that travels inside one pass
  typedef struct packed {
    logic               vld;
    logic               last;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] r2;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               zero;
  } lpu_ictx_t;

  // Clip to signed Q2.30
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return Q30_MAX;
    end else if (v < -66'sd2147483648) begin
      return Q30_MIN;
    end
    return 32'(v);
  endfunction

  // Right shift with rounding half toward plus infinity
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input int unsigned s);
    logic signed [65:0] h;
    h = 66'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

endpackage

FILE: rtl/lpu_div.sv
// Pipelined unsigned divider with rounding-ready numerator, sign and Q2.30 clipping.
// Depends on lpu_pkg; one quotient bit is resolved in each stage.
`timescale 1ns / 1ps

module lpu_div (
  input  logic               clk,
  input  logic               en,
  input  logic [62:0]        num_i,
  input  logic [32:0]        den_i,
  input  logic               neg_i,
  output logic signed [31:0] quo_o
);

  localparam int NS = lpu_pkg::DIV_QBITS;

  logic [62:0]   rem_r [0:NS];
  logic [32:0]   den_r [0:NS];
  logic [NS-1:0] q_r   [0:NS];
  logic          neg_r [0:NS];
  logic          ovf_r [0:NS];
  logic signed [31:0] quo_r;

  // Capture operands; a quotient of 2^32 or more clips whatever its sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      q_r[0]   <= '0;
      neg_r[0] <= neg_i;
      ovf_r[0] <= ({2'b00, num_i[62:32]} >= den_i);
    end
  end

  // Resolve one quotient bit per stage, most significant first
  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int B = NS - s;
    logic [63:0] dsh;
    logic        ge;
    assign dsh = 64'(den_r[s-1]) << B;
    assign ge  = ({1'b0, rem_r[s-1]} >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_r[s-1] - dsh[62:0]) : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= q_r[s-1] | (NS'(ge) << B);
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  // Apply sign and clip to Q2.30
  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_r[NS]) begin
        quo_r <= (ovf_r[NS] || q_r[NS][31]) ? lpu_pkg::Q30_MAX : $signed(q_r[NS]);
      end else begin
        quo_r <= (ovf_r[NS] || (q_r[NS][31] && (q_r[NS][30:0] != '0))) ?
                 lpu_pkg::Q30_MIN : -$signed(q_r[NS]);
      end
    end
  end

  assign quo_o = quo_r;

endmodule

FILE: rtl/lpu_iter.sv
// One refinement pass: radial factor, its reciprocal, tangential offset and rescale.
// Depends on lpu_pkg and lpu_div.
`timescale 1ns / 1ps

module lpu_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic signed [23:0]  k1,
  input  logic signed [23:0]  k2,
  input  logic signed [23:0]  k3,
  input  logic signed [23:0]  p1,
  input  logic signed [23:0]  p2,
  input  lpu_pkg::lpu_ctx_t   in_ctx,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  output lpu_pkg::lpu_ctx_t   out_ctx,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y
);

  localparam int NL = lpu_pkg::ITER_LAT;
  localparam int ST_K_PREV = lpu_pkg::ST_K - 1;

  lpu_pkg::lpu_ictx_t ictx_r   [0:NL-1];
  lpu_pkg::lpu_ictx_t ictx_nxt [0:NL-1];

  logic signed [63:0] px_r, py_r, pxy_r;
  logic signed [31:0] xx_r, yy_r, xy_r;
  logic signed [31:0] xxc_r, yyc_r, xyc_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [55:0] m3_r, t1_r, t4_r, t2_r, t3_r;
  logic signed [36:0] t1s_r, t4s_r;
  logic signed [31:0] acc1_r, acc2_r;
  logic signed [63:0] m2_r, m1_r;
  logic signed [31:0] dx_r, dy_r, poly_r;
  logic signed [33:0] den_s;
  logic [32:0]        dmag;
  logic [62:0]        num_r;
  logic [32:0]        den_r;
  logic               neg_r;
  logic signed [31:0] ic_q, ic;
  logic signed [63:0] mx_r, my_r;
  logic signed [31:0] x_r, y_r;
  logic signed [31:0] r2_nxt, ex_nxt, ey_nxt;

  // Context path: shift every stage, fill fields where they are produced
  always_comb begin
    ictx_nxt[0] = '{vld: in_ctx.vld, last: in_ctx.last, x0: in_ctx.x0, y0: in_ctx.y0,
                    r2: '0, ex: '0, ey: '0, zero: 1'b0};
    for (int k = 1; k < NL; k++) begin
      ictx_nxt[k] = ictx_r[k-1];
    end
    ictx_nxt[lpu_pkg::ST_C].r2   = r2_nxt;
    ictx_nxt[lpu_pkg::ST_G].ex   = ex_nxt;
    ictx_nxt[lpu_pkg::ST_G].ey   = ey_nxt;
    ictx_nxt[lpu_pkg::ST_J].zero = (den_s == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NL; k++) begin
        ictx_r[k].vld <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < NL; k++) begin
        ictx_r[k] <= ictx_nxt[k];
      end
    end
  end

  assign r2_nxt = lpu_pkg::sat32(66'(xx_r) + 66'(yy_r));
  assign ex_nxt = lpu_pkg::sat32(66'(ictx_r[lpu_pkg::ST_F].x0) - 66'(dx_r));
  assign ey_nxt = lpu_pkg::sat32(66'(ictx_r[lpu_pkg::ST_F].y0) - 66'(dy_r));

  // Radial factor 1 + poly as a 34 bit signed value and its magnitude
  assign den_s = 34'sd1073741824 + 34'(poly_r);
  assign dmag  = den_s[33] ? 33'(-den_s) : 33'(den_s);

  // Datapath stages A through J
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= in_x * in_x;
      py_r   <= in_y * in_y;
      pxy_r  <= in_x * in_y;

      xx_r   <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(px_r), 30));
      yy_r   <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(py_r), 30));
      xy_r   <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(pxy_r), 30));

      xxc_r  <= xx_r;
      yyc_r  <= yy_r;
      xyc_r  <= xy_r;

      rx_r   <= lpu_pkg::sat32(66'(ictx_r[lpu_pkg::ST_C].r2) + (66'(xxc_r) <<< 1));
      ry_r   <= lpu_pkg::sat32(66'(ictx_r[lpu_pkg::ST_C].r2) + (66'(yyc_r) <<< 1));
      m3_r   <= k3 * ictx_r[lpu_pkg::ST_C].r2;
      t1_r   <= p1 * xyc_r;
      t4_r   <= p2 * xyc_r;

      acc1_r <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(m3_r), 20) + (66'(k2) <<< 10));
      t2_r   <= p2 * rx_r;
      t3_r   <= p1 * ry_r;
      t1s_r  <= 37'(lpu_pkg::rnd_shr(66'(t1_r), 20));
      t4s_r  <= 37'(lpu_pkg::rnd_shr(66'(t4_r), 20));

      m2_r   <= acc1_r * ictx_r[lpu_pkg::ST_E].r2;
      dx_r   <= lpu_pkg::sat32((66'(t1s_r) <<< 1) + lpu_pkg::rnd_shr(66'(t2_r), 20));
      dy_r   <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(t3_r), 20) + (66'(t4s_r) <<< 1));

      acc2_r <= lpu_pkg::sat32(66'(lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(m2_r), 30)))
                               + (66'(k1) <<< 10));

      m1_r   <= acc2_r * ictx_r[lpu_pkg::ST_G].r2;

      poly_r <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(m1_r), 30));

      num_r  <= (63'd1 << 60) + 63'(dmag[32:1]);
      den_r  <= dmag;
      neg_r  <= den_s[33];
    end
  end

  // Reciprocal of the radial factor
  lpu_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num_r),
    .den_i (den_r),
    .neg_i (neg_r),
    .quo_o (ic_q)
  );

  // A vanishing radial factor gives the largest reciprocal
  assign ic = ictx_r[ST_K_PREV].zero ? lpu_pkg::Q30_MAX : ic_q;

  // Stages K and L: rescale the start point
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= ictx_r[ST_K_PREV].ex * ic;
      my_r <= ictx_r[ST_K_PREV].ey * ic;
      x_r  <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(mx_r), 30));
      y_r  <= lpu_pkg::sat32(lpu_pkg::rnd_shr(66'(my_r), 30));
    end
  end

  assign out_ctx = '{vld: ictx_r[NL-1].vld, last: ictx_r[NL-1].last,
                     x0: ictx_r[NL-1].x0, y0: ictx_r[NL-1].y0};
  assign out_x = x_r;
  assign out_y = y_r;

`ifndef SYNTH
  // Zero flag is only raised for a zero radial factor
  a_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ictx_r[lpu_pkg::ST_I].vld && (den_s != '0)) |=>
      !ictx_r[lpu_pkg::ST_J].zero)
    else $error("zero flag set for nonzero radial factor");
  // Frozen pipeline keeps its last valid bit
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ictx_r[NL-1].vld))
    else $error("pass output moved while frozen");
  // Divider operand always nonzero unless flagged
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    (ictx_r[lpu_pkg::ST_J].vld && !ictx_r[lpu_pkg::ST_J].zero) |-> (den_r != '0))
    else $error("zero divisor reached the divider");
`endif

endmodule

FILE: rtl/lens_point_undistort_top.sv
// Top level of the lens point undistortion block: registers, normalization, passes, output.
// Depends on lpu_pkg, lpu_div and lpu_iter.
`timescale 1ns / 1ps

// Undistorts one pixel point per clock while the output is not stalled. A point accepted on
// in_* passes through normalization, the six refinement passes and the return to pixels
// before it appears on out_*; the dividers resolve one quotient bit per stage. The pipeline
// freezes as a whole while a finished word waits on out_stall, and in_stall follows. Write
// configuration only while no point is in flight.
module lens_point_undistort_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] in_point_x,
  input  logic signed [19:0] in_point_y,
  input  logic               in_last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_undistorted_x,
  output logic signed [19:0] out_undistorted_y,
  output logic               out_saturated,
  output logic               out_last_out
);

  localparam int NI = lpu_pkg::ITERATIONS;
  localparam int ND = lpu_pkg::DIV_LAT;

  logic [19:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic signed [23:0] k1_r, k2_r, k3_r;
  logic [47:0] tang_r;
  logic en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 20'd256;
      focal_y_r  <= 20'd256;
      center_x_r <= '0;
      center_y_r <= '0;
      k1_r       <= '0;
      k2_r       <= '0;
      k3_r       <= '0;
      tang_r     <= '0;
    end else if (cfg_we) begin
      case (lpu_pkg::lpu_reg_t'(cfg_index))
        lpu_pkg::REG_FOCAL_X:    focal_x_r  <= cfg_data[19:0];
        lpu_pkg::REG_FOCAL_Y:    focal_y_r  <= cfg_data[19:0];
        lpu_pkg::REG_CENTER_X:   center_x_r <= cfg_data[19:0];
        lpu_pkg::REG_CENTER_Y:   center_y_r <= cfg_data[19:0];
        lpu_pkg::REG_RADIAL_K1:  k1_r       <= cfg_data[23:0];
        lpu_pkg::REG_RADIAL_K2:  k2_r       <= cfg_data[23:0];
        lpu_pkg::REG_RADIAL_K3:  k3_r       <= cfg_data[23:0];
        lpu_pkg::REG_TANGENTIAL: tang_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished word is held
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Normalization operands: |p - c| * 2^32 + f/2 over f, zero focal acts as one
  logic signed [21:0] dx, dy;
  logic [20:0]        ax, ay;
  logic [19:0]        fex, fey;
  logic signed [31:0] x0_q, y0_q;

  assign dx  = 22'(in_point_x) - $signed({2'b00, center_x_r});
  assign dy  = 22'(in_point_y) - $signed({2'b00, center_y_r});
  assign ax  = dx[21] ? 21'(-dx) : 21'(dx);
  assign ay  = dy[21] ? 21'(-dy) : 21'(dy);
  assign fex = (focal_x_r == '0) ? 20'd1 : focal_x_r;
  assign fey = (focal_y_r == '0) ? 20'd1 : focal_y_r;

  lpu_div u_norm_x (
    .clk   (clk),
    .en    (en),
    .num_i ({10'b0, ax, 13'b0, fex[19:1]}),
    .den_i ({13'b0, fex}),
    .neg_i (dx[21]),
    .quo_o (x0_q)
  );

  lpu_div u_norm_y (
    .clk   (clk),
    .en    (en),
    .num_i ({10'b0, ay, 13'b0, fey[19:1]}),
    .den_i ({13'b0, fey}),
    .neg_i (dy[21]),
    .quo_o (y0_q)
  );

  // Valid and batch mark alongside the normalization dividers
  logic nvld_r  [0:ND-1];
  logic nlast_r [0:ND-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ND; k++) begin
        nvld_r[k] <= 1'b0;
      end
    end else if (en) begin
      nvld_r[0]  <= in_valid;
      nlast_r[0] <= in_last_point;
      for (int k = 1; k < ND; k++) begin
        nvld_r[k]  <= nvld_r[k-1];
        nlast_r[k] <= nlast_r[k-1];
      end
    end
  end

  // Chain of refinement passes
  lpu_pkg::lpu_ctx_t  ctx [0:NI];
  logic signed [31:0] px  [0:NI];
  logic signed [31:0] py  [0:NI];

  assign ctx[0] = '{vld: nvld_r[ND-1], last: nlast_r[ND-1], x0: x0_q, y0: y0_q};
  assign px[0]  = x0_q;
  assign py[0]  = y0_q;

  for (genvar i = 0; i < NI; i++) begin : g_pass
    lpu_iter u_iter (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .k1      (k1_r),
      .k2      (k2_r),
      .k3      (k3_r),
      .p1      ($signed(tang_r[47:24])),
      .p2      ($signed(tang_r[23:0])),
      .in_ctx  (ctx[i]),
      .in_x    (px[i]),
      .in_y    (py[i]),
      .out_ctx (ctx[i+1]),
      .out_x   (px[i+1]),
      .out_y   (py[i+1])
    );
  end

  // Back to pixels: product, then round, add center and clamp
  logic signed [52:0] mx_r, my_r;
  logic               p1_vld_r, p1_last_r;
  logic signed [65:0] rx, ry;
  logic               clx, cly;
  logic signed [19:0] ox, oy;
  logic signed [19:0] ox_r, oy_r;
  logic               sat_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= ctx[NI].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_last_r <= ctx[NI].last;
      mx_r      <= px[NI] * $signed({1'b0, focal_x_r});
      my_r      <= py[NI] * $signed({1'b0, focal_y_r});
    end
  end

  always_comb begin
    rx  = lpu_pkg::rnd_shr(66'(mx_r), 32) + $signed(66'(center_x_r));
    ry  = lpu_pkg::rnd_shr(66'(my_r), 32) + $signed(66'(center_y_r));
    clx = (rx > 66'(lpu_pkg::OUT_MAX)) || (rx < 66'(lpu_pkg::OUT_MIN));
    cly = (ry > 66'(lpu_pkg::OUT_MAX)) || (ry < 66'(lpu_pkg::OUT_MIN));
    ox  = (rx > 66'(lpu_pkg::OUT_MAX)) ? lpu_pkg::OUT_MAX :
          (rx < 66'(lpu_pkg::OUT_MIN)) ? lpu_pkg::OUT_MIN : 20'(rx);
    oy  = (ry > 66'(lpu_pkg::OUT_MAX)) ? lpu_pkg::OUT_MAX :
          (ry < 66'(lpu_pkg::OUT_MIN)) ? lpu_pkg::OUT_MIN : 20'(ry);
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r   <= ox;
      oy_r   <= oy;
      sat_r  <= clx || cly;
      last_r <= p1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_undistorted_x = ox_r;
  assign out_undistorted_y = oy_r;
  assign out_saturated     = sat_r;
  assign out_last_out      = last_r;

`ifndef SYNTH
  // Input is only held back by a held output word
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without output backpressure");
  // A clamped word sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_undistorted_x == lpu_pkg::OUT_MAX || out_undistorted_x == lpu_pkg::OUT_MIN ||
       out_undistorted_y == lpu_pkg::OUT_MAX || out_undistorted_y == lpu_pkg::OUT_MIN))
    else $error("saturated word off the rails");
  // Frozen pipeline keeps the word before the output
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p1_vld_r))
    else $error("pipeline moved while frozen");
`endif

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for lens_point_undistort_top: random and directed points are
// checked against a fixed-point undistortion predictor. Depends on rtl/lpu_pkg.sv.
`timescale 1ns / 1ps

typedef struct {
  logic [19:0] ux;
  logic [19:0] uy;
  logic        sat;
  logic        last;
} undist_word_t;

class undistort_scoreboard;
  bit [19:0] focal_x, focal_y, center_x, center_y;
  bit [23:0] k1_raw, k2_raw, k3_raw;
  bit [47:0] tang_raw;
  undist_word_t pending[$];
  int errors;

  function new();
    focal_x = 20'd256;
    focal_y = 20'd256;
    center_x = '0;
    center_y = '0;
    k1_raw = '0;
    k2_raw = '0;
    k3_raw = '0;
    tang_raw = '0;
    errors = 0;
  endfunction

  // Mirror a register write, masked to the register width
  function void set_reg(lpu_pkg::lpu_reg_t idx, bit [47:0] v);
    case (idx)
      lpu_pkg::REG_FOCAL_X:    focal_x = v[19:0];
      lpu_pkg::REG_FOCAL_Y:    focal_y = v[19:0];
      lpu_pkg::REG_CENTER_X:   center_x = v[19:0];
      lpu_pkg::REG_CENTER_Y:   center_y = v[19:0];
      lpu_pkg::REG_RADIAL_K1:  k1_raw = v[23:0];
      lpu_pkg::REG_RADIAL_K2:  k2_raw = v[23:0];
      lpu_pkg::REG_RADIAL_K3:  k3_raw = v[23:0];
      lpu_pkg::REG_TANGENTIAL: tang_raw = v;
      default: ;
    endcase
  endfunction

  function longint clip30(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Shift right with rounding half toward plus infinity
  function longint round_shift(longint v, int s);
    longint h;
    h = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -(((-v) + h - 1) >>> s);
  endfunction

  // Divide with rounding half away from zero
  function longint round_div(longint num, longint den);
    longint unsigned n, d, q;
    longint r;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + d / 2) / d;
    r = (q > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'(q);
    return ((num < 0) != (den < 0)) ? -r : r;
  endfunction

  function longint qmul(longint a, longint b);
    return clip30(round_shift(a * b, 30));
  endfunction

  function longint kmul(longint k, longint v);
    return round_shift(k * v, 20);
  endfunction

  function longint to_norm(bit [19:0] p, bit [19:0] c, bit [19:0] f);
    longint d, fd;
    d = longint'($signed(p)) - longint'(c);
    fd = (f == 0) ? 1 : longint'(f);
    return clip30(round_div(d * 64'sd4294967296, fd));
  endfunction

  function logic [19:0] to_pix(longint v, bit [19:0] f, bit [19:0] c, inout logic clamped);
    longint r;
    r = round_shift(v * longint'(f), 32) + longint'(c);
    if (r > 524287) begin
      clamped = 1'b1;
      r = 524287;
    end else if (r < -524288) begin
      clamped = 1'b1;
      r = -524288;
    end
    return r[19:0];
  endfunction

  // Predict the undistorted point for one accepted word
  function void note_point(logic [19:0] px, logic [19:0] py, logic lst);
    longint k1, k2, k3, p1, p2, x0, y0, x, y;
    longint xx, yy, xy, r2, acc, poly, den, icd, dx, dy;
    undist_word_t w;
    logic clamped;
    k1 = $signed(k1_raw);
    k2 = $signed(k2_raw);
    k3 = $signed(k3_raw);
    p1 = $signed(tang_raw[47:24]);
    p2 = $signed(tang_raw[23:0]);
    x0 = to_norm(px, center_x, focal_x);
    y0 = to_norm(py, center_y, focal_y);
    x = x0;
    y = y0;
    for (int it = 0; it < lpu_pkg::ITERATIONS; it++) begin
      xx = qmul(x, x);
      yy = qmul(y, y);
      xy = qmul(x, y);
      r2 = clip30(xx + yy);
      acc = clip30(kmul(k3, r2) + k2 * 1024);
      acc = clip30(qmul(acc, r2) + k1 * 1024);
      poly = qmul(acc, r2);
      den = 64'sd1073741824 + poly;
      icd = (den == 0) ? 64'sd2147483647 : clip30(round_div(64'sd1152921504606846976, den));
      dx = clip30(2 * kmul(p1, xy) + kmul(p2, clip30(r2 + 2 * xx)));
      dy = clip30(kmul(p1, clip30(r2 + 2 * yy)) + 2 * kmul(p2, xy));
      x = qmul(clip30(x0 - dx), icd);
      y = qmul(clip30(y0 - dy), icd);
    end
    clamped = 1'b0;
    w.ux = to_pix(x, focal_x, center_x, clamped);
    w.uy = to_pix(y, focal_y, center_y, clamped);
    w.sat = clamped;
    w.last = lst;
    pending.push_back(w);
  endfunction

  // Compare a result word against the oldest prediction
  function void check_point(logic [19:0] ux, logic [19:0] uy, logic sat, logic lst);
    undist_word_t w;
    if (pending.size() == 0) begin
      $error("unexpected result word x=%0h y=%0h", ux, uy);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (ux !== w.ux) begin
      $error("undistorted_x expected %0h actual %0h", w.ux, ux);
      errors++;
    end
    if (uy !== w.uy) begin
      $error("undistorted_y expected %0h actual %0h", w.uy, uy);
      errors++;
    end
    if (sat !== w.sat) begin
      $error("saturated expected %0b actual %0b", w.sat, sat);
      errors++;
    end
    if (lst !== w.last) begin
      $error("last_out expected %0b actual %0b", w.last, lst);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [19:0] in_point_x = '0;
  logic signed [19:0] in_point_y = '0;
  logic               in_last_point = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [19:0] out_undistorted_x;
  logic signed [19:0] out_undistorted_y;
  logic               out_saturated;
  logic               out_last_out;

  undistort_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  lens_point_undistort_top uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("lens_point_undistort_top verification failed");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_point(in_point_x, in_point_y, in_last_point);
    if (rst_n && out_valid && !out_stall)
      sb.check_point(out_undistorted_x, out_undistorted_y, out_saturated, out_last_out);
  end

  function void set_phase(int ph);
    case (ph % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 53; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 53; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endfunction

  // Write one register; bits above its width carry junk
  task write_reg(lpu_pkg::lpu_reg_t idx, logic [47:0] value);
    logic [47:0] mask, junk;
    mask = (idx == lpu_pkg::REG_TANGENTIAL) ? 48'hFFFF_FFFF_FFFF :
           (idx >= lpu_pkg::REG_RADIAL_K1) ? 48'hFF_FFFF : 48'hF_FFFF;
    junk = 48'({$urandom, $urandom});
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (value & mask) | (junk & ~mask);
    sb.set_reg(idx, (value & mask) | (junk & ~mask));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task send_point(logic [19:0] px, logic [19:0] py, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_last_point <= lst;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Hold until every predicted word has come back, then let the pipe settle
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task send_directed();
    send_point(20'h00000, 20'h00000, 1'b0);
    send_point(20'h7FFFF, 20'h7FFFF, 1'b1);
    send_point(20'h80000, 20'h80000, 1'b0);
    send_point(20'h7FFFF, 20'h80000, 1'b1);
    send_point(20'h00001, 20'hFFFFF, 1'b0);
    send_point(20'd64, 20'd0, 1'b0);
    send_point(20'd0, 20'd64, 1'b1);
    send_point(20'hAAAAA, 20'h55555, 1'b0);
    send_point(20'h55555, 20'hAAAAA, 1'b1);
  endtask

  function logic [23:0] small_coeff(int span);
    return 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  task apply_setting(int which);
    case (which)
      1, 6: begin
        write_reg(lpu_pkg::REG_FOCAL_X, 48'($urandom_range(1500, 300)) << 8);
        write_reg(lpu_pkg::REG_FOCAL_Y, 48'($urandom_range(1500, 300)) << 8);
        write_reg(lpu_pkg::REG_CENTER_X, 48'($urandom_range(800, 200)) << 6);
        write_reg(lpu_pkg::REG_CENTER_Y, 48'($urandom_range(600, 150)) << 6);
        write_reg(lpu_pkg::REG_RADIAL_K1, 48'(small_coeff(300000)));
        write_reg(lpu_pkg::REG_RADIAL_K2, 48'(small_coeff(100000)));
        write_reg(lpu_pkg::REG_RADIAL_K3, 48'(small_coeff(30000)));
        write_reg(lpu_pkg::REG_TANGENTIAL, {small_coeff(10000), small_coeff(10000)});
      end
      2: begin
        // radial factor collapses to zero for a unit-radius point
        write_reg(lpu_pkg::REG_FOCAL_X, 48'd256);
        write_reg(lpu_pkg::REG_FOCAL_Y, 48'd256);
        write_reg(lpu_pkg::REG_CENTER_X, 48'd0);
        write_reg(lpu_pkg::REG_CENTER_Y, 48'd0);
        write_reg(lpu_pkg::REG_RADIAL_K1, 48'hF0_0000);
        write_reg(lpu_pkg::REG_RADIAL_K2, 48'd0);
        write_reg(lpu_pkg::REG_RADIAL_K3, 48'd0);
        write_reg(lpu_pkg::REG_TANGENTIAL, 48'd0);
      end
      3: begin
        write_reg(lpu_pkg::REG_FOCAL_X, 48'hF_FFFF);
        write_reg(lpu_pkg::REG_FOCAL_Y, 48'hF_FFFF);
        write_reg(lpu_pkg::REG_CENTER_X, 48'hF_FFFF);
        write_reg(lpu_pkg::REG_CENTER_Y, 48'hF_FFFF);
        write_reg(lpu_pkg::REG_RADIAL_K1, 48'h7F_FFFF);
        write_reg(lpu_pkg::REG_RADIAL_K2, 48'h7F_FFFF);
        write_reg(lpu_pkg::REG_RADIAL_K3, 48'h7F_FFFF);
        write_reg(lpu_pkg::REG_TANGENTIAL, 48'h7FFFFF_7FFFFF);
      end
      4: begin
        // zero focal lengths act as one
        write_reg(lpu_pkg::REG_FOCAL_X, 48'd0);
        write_reg(lpu_pkg::REG_FOCAL_Y, 48'd0);
        write_reg(lpu_pkg::REG_CENTER_X, 48'd0);
        write_reg(lpu_pkg::REG_CENTER_Y, 48'd0);
        write_reg(lpu_pkg::REG_RADIAL_K1, 48'h80_0000);
        write_reg(lpu_pkg::REG_RADIAL_K2, 48'h80_0000);
        write_reg(lpu_pkg::REG_RADIAL_K3, 48'h80_0000);
        write_reg(lpu_pkg::REG_TANGENTIAL, 48'h800000_800000);
      end
      5: begin
        write_reg(lpu_pkg::REG_FOCAL_X, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_FOCAL_Y, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_CENTER_X, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_CENTER_Y, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_RADIAL_K1, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_RADIAL_K2, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_RADIAL_K3, 48'({$urandom, $urandom}));
        write_reg(lpu_pkg::REG_TANGENTIAL, 48'({$urandom, $urandom}));
      end
      default: ;
    endcase
  endtask

  // Half full-range points, half near the principal point
  task send_random(int count);
    logic [19:0] px, py;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) begin
        px = 20'($urandom);
        py = 20'($urandom);
      end else begin
        px = sb.center_x + 20'($signed($urandom_range(60000)) - 30000);
        py = sb.center_y + 20'($signed($urandom_range(60000)) - 30000);
      end
      send_point(px, py, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int s = 0; s < 7; s++) begin
      set_phase(s);
      apply_setting(s);
      if (s == 0 || s == 2 || s == 3)
        send_directed();
      send_random(50);
      set_phase(s + 1);
      send_random(50);
      drain();
    end

    repeat (330) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lens_point_undistort_top verification clean");
    end else begin
      $display("lens_point_undistort_top verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/lpu_pkg.sv
rtl/lpu_div.sv
rtl/lpu_iter.sv
rtl/lens_point_undistort_top.sv
dv/testbench.sv
